// ===== sv/dense_layer_sigmoid_forward_macros.svh =====
// assertion macros for the dense layer block
// used by dense_layer_sigmoid_forward.sv
`ifndef DENSE_LAYER_SIGMOID_FORWARD_MACROS_SVH
`define DENSE_LAYER_SIGMOID_FORWARD_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DLS_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DLS_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DLS_ASSERT_NOW(label, ck, rs, ante, cons)
`define DLS_ASSERT_NEXT(label, ck, rs, ante, cons)
`endif
`endif

// ===== sv/dls_pkg.sv =====
// constants, types and sigmoid table for the dense layer block
// no dependencies
package dls_pkg;
  localparam int MAX_INPUTS = 1024;
  localparam int MAX_NEURONS = 64;
  localparam int SIG_DEPTH = 256;
  localparam int IN_W = $clog2(MAX_INPUTS);
  localparam int NRN_W = $clog2(MAX_NEURONS);
  localparam int WADDR_W = IN_W + NRN_W;
  localparam int SEG_W = $clog2(SIG_DEPTH);
  localparam int FRAC_W = 30 - SEG_W;
  localparam int ACC_W = 32 + IN_W + 2;
  localparam logic [10:0] INPUT_COUNT_RST = 11'(28 * 28);
  localparam logic [6:0] NEURON_COUNT_RST = 7'd10;

  // input kinds
  localparam logic [1:0] KIND_WEIGHT = 2'd0;
  localparam logic [1:0] KIND_BIAS = 2'd1;
  localparam logic [1:0] KIND_ACT = 2'd2;

  // register indexes
  localparam logic [1:0] REG_INPUT_COUNT = 2'd0;
  localparam logic [1:0] REG_NEURON_COUNT = 2'd1;

  typedef logic [14:0] sig_tab_t [0:SIG_DEPTH];

  // restoring division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [14:0] pos_side(input logic [63:0] q);
    logic [63:0] den;
    logic [63:0] s;
    den = 64'd1073741824 + q;
    s = udiv64((64'd1073741824 << 15) + (den >> 1), den);
    return (s > 64'd32767) ? 15'd32767 : s[14:0];
  endfunction

  function automatic sig_tab_t build_table();
    sig_tab_t t;
    logic [63:0] term;
    logic signed [63:0] acc;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] d;
    logic [14:0] s;
    logic [15:0] neg;
    d = 64'(SIG_DEPTH);
    term = 64'd1073741824;
    acc = 64'sd1073741824;
    q = 64'd1073741824;
    for (int i = 1; i <= 20; i++) begin
      term = udiv64(term * 64'd8, d * 64'(i));
      if (i % 2 == 1) acc = acc - $signed(term);
      else acc = acc + $signed(term);
    end
    r = $unsigned(acc);
    for (int m = 0; m <= SIG_DEPTH; m++) begin
      if ((SIG_DEPTH + m) % 2 == 0) begin
        s = pos_side(q);
        neg = 16'd32768 - {1'b0, s};
        t[(SIG_DEPTH + m) / 2] = s;
        t[(SIG_DEPTH - m) / 2] = (neg > 16'd32767) ? 15'd32767 : neg[14:0];
      end
      q = (q * r + 64'd536870912) >> 30;
    end
    return t;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_table();

  // status shared with checks
  typedef struct packed {
    logic busy;
    logic done;
  } dls_status_t;
endpackage

// ===== sv/dense_layer_sigmoid_forward.sv =====
// fully connected layer with interpolated sigmoid, one result beat per neuron
// after the last activation beat each neuron goes through bias read, bias init, mac, drain,
// clamp, lookup, multiply, interpolate and output states; the mac reads through one weight
// memory read port, and beats are accepted only while idle, not during an evaluation
// reset (rst, synchronous) clears control, best tracker and configuration registers;
// weight, bias and activation memories hold no reset and must be loaded first
`include "dense_layer_sigmoid_forward_macros.svh"
module dense_layer_sigmoid_forward (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              kind,
  input  logic [5:0]              neuron,
  input  logic [9:0]              position,
  input  logic signed [15:0]      value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [5:0]              neuron_index,
  output logic [14:0]             activation,
  output logic [5:0]              best_neuron,
  output logic                    last,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [10:0]             cfg_data
);
  import dls_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_BREAD = 4'd1;
  localparam logic [3:0] ST_BINIT = 4'd2;
  localparam logic [3:0] ST_MAC   = 4'd3;
  localparam logic [3:0] ST_DRAIN = 4'd4;
  localparam logic [3:0] ST_SIG1  = 4'd5;
  localparam logic [3:0] ST_SIG2  = 4'd6;
  localparam logic [3:0] ST_SIG3  = 4'd7;
  localparam logic [3:0] ST_SIG4  = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  // memories
  logic signed [15:0] weight_mem [0:MAX_INPUTS*MAX_NEURONS-1];
  logic signed [15:0] bias_mem [0:MAX_NEURONS-1];
  logic signed [15:0] act_mem [0:MAX_INPUTS-1];
  logic signed [15:0] w_q;
  logic signed [15:0] b_q;
  logic signed [15:0] a_q;

  logic [10:0] input_count;
  logic [6:0] neuron_count;
  logic [IN_W:0] ni_eff;
  logic [NRN_W:0] nn_eff;

  logic [IN_W:0] col;
  logic [NRN_W-1:0] nrn;
  logic v1, l1, v2, l2;
  logic signed [31:0] prod;
  logic signed [ACC_W-1:0] acc;

  logic [30:0] u;
  logic [14:0] lo;
  logic [14:0] diff;
  logic [FRAC_W-1:0] frac;
  logic [15+FRAC_W-1:0] iprod;
  logic [14:0] act_val;
  logic [14:0] best_value;
  logic [5:0] best_index;
  dls_status_t status;

  logic in_fire;
  logic out_fire;
  logic start;
  logic last_issue;

  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  // effective register values
  always_comb begin
    if (input_count == 11'd0) ni_eff = (IN_W+1)'(1);
    else if (input_count > 11'(MAX_INPUTS)) ni_eff = (IN_W+1)'(MAX_INPUTS);
    else ni_eff = (IN_W+1)'(input_count);
    if (neuron_count == 7'd0) nn_eff = (NRN_W+1)'(1);
    else if (neuron_count > 7'(MAX_NEURONS)) nn_eff = (NRN_W+1)'(MAX_NEURONS);
    else nn_eff = (NRN_W+1)'(neuron_count);
  end

  assign start = in_fire && (kind == KIND_ACT)
                 && ({1'b0, position} == ni_eff - (IN_W+1)'(1));
  assign last_issue = (col == ni_eff - (IN_W+1)'(1));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      input_count <= INPUT_COUNT_RST;
      neuron_count <= NEURON_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INPUT_COUNT: input_count <= cfg_data;
        REG_NEURON_COUNT: neuron_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // weight memory: load port and mac read port
  always_ff @(posedge clk) begin
    if (in_fire && kind == KIND_WEIGHT) weight_mem[{neuron, position}] <= value;
    w_q <= weight_mem[{nrn, col[IN_W-1:0]}];
  end

  // bias memory
  always_ff @(posedge clk) begin
    if (in_fire && kind == KIND_BIAS) bias_mem[neuron] <= value;
    b_q <= bias_mem[nrn];
  end

  // activation memory
  always_ff @(posedge clk) begin
    if (in_fire && kind == KIND_ACT) act_mem[position] <= value;
    a_q <= act_mem[col[IN_W-1:0]];
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_BREAD;
      ST_BREAD: state_next = ST_BINIT;
      ST_BINIT: state_next = ST_MAC;
      ST_MAC: if (last_issue) state_next = ST_DRAIN;
      ST_DRAIN: if (v2 && l2) state_next = ST_SIG1;
      ST_SIG1: state_next = ST_SIG2;
      ST_SIG2: state_next = ST_SIG3;
      ST_SIG3: state_next = ST_SIG4;
      ST_SIG4: state_next = ST_OUT;
      ST_OUT: begin
        if (out_fire) state_next = last ? ST_IDLE : ST_BREAD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // neuron and column counters
  always_ff @(posedge clk) begin
    if (rst) begin
      nrn <= '0;
      col <= '0;
    end else begin
      if (state == ST_IDLE) nrn <= '0;
      else if (state == ST_OUT && out_fire) nrn <= nrn + NRN_W'(1);
      if (state == ST_MAC) col <= col + (IN_W+1)'(1);
      else col <= '0;
    end
  end

  // mac pipeline: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      l1 <= 1'b0;
      v2 <= 1'b0;
      l2 <= 1'b0;
    end else begin
      v1 <= (state == ST_MAC);
      l1 <= (state == ST_MAC) && last_issue;
      v2 <= v1;
      l2 <= v1 && l1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= w_q * a_q;
    if (state == ST_BINIT) acc <= ACC_W'(b_q) <<< 15;
    else if (v2) acc <= acc + ACC_W'(prod);
  end

  // sigmoid: clamp, table lookup, interpolate
  always_ff @(posedge clk) begin
    if (state == ST_SIG1) begin
      if (acc > ACC_W'(64'sd536870912)) u <= 31'h40000000;
      else if (acc < -ACC_W'(64'sd536870912)) u <= '0;
      else u <= 31'(acc + ACC_W'(64'sd536870912));
    end
    if (state == ST_SIG2) begin
      lo <= SIG_TABLE[u[30:FRAC_W]];
      if (u[30:FRAC_W] == (SEG_W+1)'(SIG_DEPTH)) diff <= '0;
      else if (SIG_TABLE[u[30:FRAC_W] + (SEG_W+1)'(1)] < SIG_TABLE[u[30:FRAC_W]])
        diff <= '0;
      else
        diff <= SIG_TABLE[u[30:FRAC_W] + (SEG_W+1)'(1)] - SIG_TABLE[u[30:FRAC_W]];
      frac <= u[FRAC_W-1:0];
    end
    if (state == ST_SIG3) iprod <= diff * frac;
  end

  assign act_val = lo + 15'((iprod + (15+FRAC_W)'(1 << (FRAC_W-1))) >> FRAC_W);

  // result register and running argmax
  always_ff @(posedge clk) begin
    if (rst) begin
      best_value <= '0;
      best_index <= '0;
    end else if (state == ST_SIG4) begin
      if (nrn == '0 || act_val >= best_value) begin
        best_value <= act_val;
        best_index <= 6'(nrn);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SIG4) begin
      neuron_index <= 6'(nrn);
      activation <= act_val;
      last <= ({1'b0, nrn} == nn_eff - (NRN_W+1)'(1));
    end
  end

  assign best_neuron = best_index;

  assign status.busy = (state != ST_IDLE);
  assign status.done = out_fire && last;

  `DLS_ASSERT_NOW(a_out_busy, clk, rst, out_valid, status.busy && !in_ready)
  `DLS_ASSERT_NEXT(a_last_idle, clk, rst, status.done, in_ready)
  `DLS_ASSERT_NEXT(a_more_work, clk, rst, out_fire && !last, !out_valid && !in_ready)
  `DLS_ASSERT_NEXT(a_start_busy, clk, rst, start, state == ST_BREAD)
endmodule

// ===== tb/sv/tb_dense_layer_sigmoid_forward.sv =====
// self-checking testbench for dense_layer_sigmoid_forward
// depends on dls_pkg (kind and register codes, sizes, reset counts) and the block itself
`timescale 1ns / 1ps
module tb_dense_layer_sigmoid_forward;
  import dls_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int TAB_N = 256;
  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE = 30;

  typedef struct {
    logic [1:0] kind;
    logic [5:0] row;
    logic [9:0] col;
    logic signed [15:0] val;
    bit typed;
    logic [14:0] typed_act;
  } dir_row_t;

  typedef struct {
    logic [5:0] idx;
    logic [14:0] act;
    logic [5:0] best;
    logic last;
  } neuron_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] kind = '0;
  logic [5:0] neuron = '0;
  logic [9:0] position = '0;
  logic signed [15:0] value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] neuron_index;
  logic [14:0] activation;
  logic [5:0] best_neuron;
  logic last;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [10:0] cfg_data = '0;

  // shadow copy of the layer
  shortint wt_mem [0:MAX_NEURONS*MAX_INPUTS-1];
  shortint bias_mem [0:MAX_NEURONS-1];
  shortint act_mem [0:MAX_INPUTS-1];
  logic [10:0] n_inputs_reg;
  logic [6:0] n_neurons_reg;
  logic [14:0] best_act;
  logic [5:0] best_idx;
  int unsigned sig_lut [0:TAB_N];

  neuron_res_t pending_res [$];
  int mismatches = 0;
  int result_beats = 0;
  int beats_sent = 0;
  bit calm = 0;
  bit hold_req = 0;
  int idle_cycles = 0;

  dense_layer_sigmoid_forward i_dut (.*);

  always #4 clk = ~clk;

  // sigmoid samples, exp powers from a truncated series
  function automatic int unsigned half_sigmoid(longint unsigned q);
    longint unsigned den, s;
    den = 64'd1073741824 + q;
    s = ((64'd1 << 45) + den / 2) / den;
    return (s > 32767) ? 32767 : int'(s);
  endfunction

  task automatic build_sig_lut();
    longint unsigned term, q, r, neg;
    longint signed acc;
    int unsigned s;
    term = 64'd1073741824;
    acc = 64'sd1073741824;
    q = 64'd1073741824;
    for (int i = 1; i <= 20; i++) begin
      term = term * 8 / (TAB_N * i);
      if (i % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    r = longint'(acc);
    for (int m = 0; m <= TAB_N; m++) begin
      if ((TAB_N + m) % 2 == 0) begin
        s = half_sigmoid(q);
        neg = 32768 - s;
        sig_lut[(TAB_N + m) / 2] = s;
        sig_lut[(TAB_N - m) / 2] = (neg > 32767) ? 32767 : int'(neg);
      end
      q = (q * r + 64'd536870912) >> 30;
    end
  endtask

  function automatic logic [14:0] sigmoid_of(longint signed z);
    longint unsigned u, p, seg, f, lo, hi;
    if (z > 64'sd536870912) z = 64'sd536870912;
    if (z < -64'sd536870912) z = -64'sd536870912;
    u = longint'(z + 64'sd536870912);
    p = u * TAB_N;
    seg = p >> 30;
    f = p & 64'h3FFF_FFFF;
    if (seg >= TAB_N) return 15'(sig_lut[TAB_N]);
    lo = sig_lut[seg];
    hi = sig_lut[seg + 1];
    if (hi < lo) hi = lo;
    return 15'(lo + (((hi - lo) * f + 64'd536870912) >> 30));
  endfunction

  function automatic int eff_inputs();
    int n;
    n = n_inputs_reg;
    if (n == 0) n = 1;
    if (n > MAX_INPUTS) n = MAX_INPUTS;
    return n;
  endfunction

  function automatic int eff_neurons();
    int n;
    n = n_neurons_reg;
    if (n == 0) n = 1;
    if (n > MAX_NEURONS) n = MAX_NEURONS;
    return n;
  endfunction

  // apply one accepted beat to the shadow layer, queue the neuron results
  task automatic predict_layer(logic [1:0] k, logic [5:0] r, logic [9:0] c,
                               logic signed [15:0] v);
    int ni, nn;
    longint signed z;
    logic [14:0] a;
    neuron_res_t res;
    ni = eff_inputs();
    nn = eff_neurons();
    case (k)
      KIND_WEIGHT: wt_mem[r * MAX_INPUTS + c] = v;
      KIND_BIAS: bias_mem[r] = v;
      KIND_ACT: begin
        act_mem[c] = v;
        if (c == ni - 1) begin
          for (int n = 0; n < nn; n++) begin
            z = longint'(bias_mem[n]) * 32768;
            for (int i = 0; i < ni; i++)
              z += longint'(wt_mem[n * MAX_INPUTS + i]) * longint'(act_mem[i]);
            a = sigmoid_of(z);
            if (n == 0 || a >= best_act) begin
              best_act = a;
              best_idx = 6'(n);
            end
            res.idx = 6'(n);
            res.act = a;
            res.best = best_idx;
            res.last = (n == nn - 1);
            pending_res = {pending_res, res};
          end
        end
      end
      default: ;
    endcase
  endtask

  // one input beat with a random lead-in gap unless calm
  task automatic send_beat(logic [1:0] k, logic [5:0] r, logic [9:0] c,
                           logic signed [15:0] v);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind = k;
    neuron = r;
    position = c;
    value = v;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_layer(k, r, c, v);
    beats_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_INPUT_COUNT) n_inputs_reg = data;
    else if (idx == REG_NEURON_COUNT) n_neurons_reg = 7'(data);
  endtask

  // noise that never triggers an evaluation
  task automatic send_noise();
    logic [9:0] c;
    logic [1:0] k;
    k = 2'($urandom_range(0, 3));
    c = 10'($urandom);
    if (k == KIND_ACT && c == eff_inputs() - 1) k = KIND_NONE;
    send_beat(k, 6'($urandom), c, 16'($urandom));
  endtask

  // full well-formed evaluation: all weights, biases, then activations
  task automatic send_evaluation(int noise_pct);
    int ni, nn;
    ni = eff_inputs();
    nn = eff_neurons();
    for (int n = 0; n < nn; n++) begin
      send_beat(KIND_BIAS, 6'(n), 10'($urandom), 16'($urandom));
      for (int i = 0; i < ni; i++) begin
        if ($urandom_range(0, 99) < noise_pct) send_noise();
        send_beat(KIND_WEIGHT, 6'(n), 10'(i), 16'($urandom));
      end
    end
    for (int i = 0; i < ni; i++) begin
      if ($urandom_range(0, 99) < noise_pct) send_noise();
      send_beat(KIND_ACT, 6'($urandom), 10'(i), 16'($urandom));
    end
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && !rst));
      check_beat();
    end
  end

  task automatic check_beat();
    neuron_res_t e;
    result_beats++;
    if (pending_res.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat neuron %0d", neuron_index);
      return;
    end
    e = pending_res.pop_front();
    if (neuron_index !== e.idx || activation !== e.act || best_neuron !== e.best ||
        last !== e.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch exp idx %0d act %0d best %0d last %0b, got %0d %0d %0d %0b",
                 e.idx, e.act, e.best, e.last, neuron_index, activation, best_neuron, last);
    end
  endtask

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("tb_dense_layer_sigmoid_forward NOT OK");
      $finish;
    end
  end

  // directed rows, single neuron over a single input
  dir_row_t dir_tab [14] = '{
    '{KIND_NONE, 6'd63, 10'd1023, -16'sd1, 1'b0, 15'd0},
    '{KIND_WEIGHT, 6'd0, 10'd0, 16'sd0, 1'b0, 15'd0},
    '{KIND_BIAS, 6'd0, 10'd0, 16'sd0, 1'b0, 15'd0},
    '{KIND_ACT, 6'd0, 10'd0, 16'sd32767, 1'b1, 15'd16384},
    '{KIND_ACT, 6'd0, 10'd5, -16'sd1, 1'b0, 15'd0},
    '{KIND_WEIGHT, 6'd0, 10'd0, 16'sd32767, 1'b0, 15'd0},
    '{KIND_BIAS, 6'd0, 10'd0, 16'sd32767, 1'b0, 15'd0},
    '{KIND_ACT, 6'd0, 10'd0, 16'sd32767, 1'b0, 15'd0},
    '{KIND_WEIGHT, 6'd0, 10'd0, -16'sd32768, 1'b0, 15'd0},
    '{KIND_BIAS, 6'd0, 10'd0, -16'sd32768, 1'b0, 15'd0},
    '{KIND_ACT, 6'd0, 10'd0, 16'sd32767, 1'b0, 15'd0},
    '{KIND_ACT, 6'd0, 10'd0, -16'sd32768, 1'b1, 15'd16384},
    '{KIND_WEIGHT, 6'd63, 10'd1023, -16'sd21846, 1'b0, 15'd0},
    '{KIND_BIAS, 6'd63, 10'd0, 16'sd21845, 1'b0, 15'd0}
  };

  initial begin
    int ni, nn, evals;
    build_sig_lut();
    n_inputs_reg = INPUT_COUNT_RST;
    n_neurons_reg = NEURON_COUNT_RST;
    best_act = '0;
    best_idx = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // zero counts read as one; spare index must do nothing
    write_reg(REG_INPUT_COUNT, 11'd0);
    write_reg(REG_NEURON_COUNT, 11'd0);
    write_reg(REG_SPARE, 11'h7FF);
    foreach (dir_tab[j]) begin
      send_beat(dir_tab[j].kind, dir_tab[j].row, dir_tab[j].col, dir_tab[j].val);
      if (dir_tab[j].typed) pending_res[pending_res.size() - 1].act = dir_tab[j].typed_act;
    end
    wait_drained();

    // widest layer over one input, then saturated neuron count
    write_reg(REG_INPUT_COUNT, 11'd1);
    write_reg(REG_NEURON_COUNT, 11'd64);
    send_evaluation(0);
    wait_drained();
    write_reg(REG_NEURON_COUNT, 11'd127);
    send_beat(KIND_ACT, 6'd0, 10'd0, 16'($urandom));
    wait_drained();

    // saturated input count: last position is 1023, so these only store
    write_reg(REG_INPUT_COUNT, 11'd2047);
    send_beat(KIND_ACT, 6'd0, 10'd1022, 16'($urandom));
    send_beat(KIND_ACT, 6'd0, 10'd0, 16'($urandom));
    wait_drained();

    // random layers, mostly small, some back to back
    evals = 0;
    while (beats_sent < 330) begin
      ni = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 6);
      nn = (ni > 8) ? $urandom_range(1, 3)
           : (($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 6));
      // the held batch gets a second neuron; input stalls while a result is held
      if (evals == 0 && nn < 2) nn = 2;
      write_reg(REG_INPUT_COUNT, 11'(ni));
      write_reg(REG_NEURON_COUNT, 11'(nn));
      calm = ($urandom_range(0, 3) == 0);
      if (evals == 0) begin
        hold_req = 1;
        calm = 0;
      end
      repeat ((evals == 0) ? 3 : $urandom_range(1, 2)) begin
        send_evaluation(20);
      end
      evals++;
      wait_drained();
    end

    if (mismatches == 0) $display("tb_dense_layer_sigmoid_forward OK");
    else $display("tb_dense_layer_sigmoid_forward NOT OK");
    $finish;
  end
endmodule
